@@ sv/wscc_pkg.sv @@
// Shared types, codes and cost table for the wait-state cycle counter.
`default_nettype none

package wscc_pkg;

  localparam int unsigned AddrW  = 28;
  localparam int unsigned SizeW  = 2;
  localparam int unsigned CountW = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [SizeW-1:0] {
    SizeByte = 2'd0,
    SizeHalf = 2'd1,
    SizeWord = 2'd2,
    SizeRsvd = 2'd3
  } size_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEwramWait = 3'd0,
    CfgNwaitRom0 = 3'd1,
    CfgNwaitRom1 = 3'd2,
    CfgNwaitRom2 = 3'd3,
    CfgNwaitSave = 3'd4,
    CfgSwaitRom0 = 3'd5,
    CfgSwaitRom1 = 3'd6,
    CfgSwaitRom2 = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    RegionSys0  = 4'd0,
    RegionSys1  = 4'd1,
    RegionEwram = 4'd2,
    RegionIwram = 4'd3,
    RegionIo    = 4'd4,
    RegionPal   = 4'd5,
    RegionVram  = 4'd6,
    RegionOam   = 4'd7,
    RegionRom0a = 4'd8,
    RegionRom0b = 4'd9,
    RegionRom1a = 4'd10,
    RegionRom1b = 4'd11,
    RegionRom2a = 4'd12,
    RegionRom2b = 4'd13,
    RegionSavea = 4'd14,
    RegionSaveb = 4'd15
  } region_e;

  typedef enum logic [1:0] {
    WinRom0 = 2'd0,
    WinRom1 = 2'd1,
    WinRom2 = 2'd2,
    WinSave = 2'd3
  } win_e;

  localparam logic [3:0] EwramWaitRst = 4'd13;

  typedef struct packed {
    logic [3:0] ewram_wait;
    logic [1:0] nwait_rom0;
    logic [1:0] nwait_rom1;
    logic [1:0] nwait_rom2;
    logic [1:0] nwait_save;
    logic       swait_rom0;
    logic       swait_rom1;
    logic       swait_rom2;
  } cfg_t;

  function automatic logic [3:0] n_cost(input logic [1:0] code);
    logic [3:0] c;
    case (code)
      2'd0:    c = 4'd5;
      2'd1:    c = 4'd4;
      2'd2:    c = 4'd3;
      default: c = 4'd9;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/wscc_cfg.sv @@
// Configuration register file for the wait-state settings.
`default_nettype none

module wscc_cfg
  import wscc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q            <= '0;
      cfg_q.ewram_wait <= EwramWaitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgEwramWait: cfg_q.ewram_wait <= cfg_data_i;
        CfgNwaitRom0: cfg_q.nwait_rom0 <= cfg_data_i[1:0];
        CfgNwaitRom1: cfg_q.nwait_rom1 <= cfg_data_i[1:0];
        CfgNwaitRom2: cfg_q.nwait_rom2 <= cfg_data_i[1:0];
        CfgNwaitSave: cfg_q.nwait_save <= cfg_data_i[1:0];
        CfgSwaitRom0: cfg_q.swait_rom0 <= cfg_data_i[0];
        CfgSwaitRom1: cfg_q.swait_rom1 <= cfg_data_i[0];
        CfgSwaitRom2: cfg_q.swait_rom2 <= cfg_data_i[0];
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/wscc_cost.sv @@
// Cycle cost decode of one bus access from region, window and settings.
`default_nettype none

module wscc_cost
  import wscc_pkg::*;
(
  input  wire logic [AddrW-1:0]  address_i,
  input  wire logic [SizeW-1:0]  access_size_i,
  input  wire logic              is_sequential_i,
  input  wire cfg_t              cfg_i,
  output logic [CountW-1:0]      cycle_count_o
);

  logic        word;
  logic        seq_eff;
  logic [4:0]  ew_cost;
  logic [3:0]  n_c;
  logic [3:0]  s_c;
  logic [3:0]  base;
  logic [CountW-1:0] cart;

  assign word    = (size_e'(access_size_i) == SizeWord);
  assign seq_eff = is_sequential_i && (address_i[16:1] != 16'd0);
  assign ew_cost = 5'd16 - {1'b0, cfg_i.ewram_wait};

  always_comb begin
    case (win_e'(address_i[26:25]))
      WinRom0: begin
        n_c = n_cost(cfg_i.nwait_rom0);
        s_c = cfg_i.swait_rom0 ? 4'd2 : 4'd3;
      end
      WinRom1: begin
        n_c = n_cost(cfg_i.nwait_rom1);
        s_c = cfg_i.swait_rom1 ? 4'd2 : 4'd5;
      end
      WinRom2: begin
        n_c = n_cost(cfg_i.nwait_rom2);
        s_c = cfg_i.swait_rom2 ? 4'd2 : 4'd9;
      end
      default: begin
        n_c = n_cost(cfg_i.nwait_save);
        s_c = n_c;
      end
    endcase
  end

  assign base = seq_eff ? s_c : n_c;
  assign cart = {2'b00, base} + (word ? {2'b00, s_c} : 6'd0);

  always_comb begin
    case (region_e'(address_i[27:24]))
      RegionSys0, RegionSys1, RegionIwram, RegionIo, RegionOam:
        cycle_count_o = 6'd1;
      RegionEwram:
        cycle_count_o = word ? {ew_cost, 1'b0} : {1'b0, ew_cost};
      RegionPal, RegionVram:
        cycle_count_o = word ? 6'd2 : 6'd1;
      default:
        cycle_count_o = cart;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/wait_state_cycle_count.sv @@
// Top level: input register, cost decode and result register of the wait-state counter.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, address_i, access_size_i, | to block
//          | is_sequential_i                                |
//  out     | out_valid_o/out_ready_i, cycle_count_o          | from block
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i               | to block
//
// One transfer per cycle sustained while out_ready_i is held high.
// The cost decode sits between the input register and the result register.
// Reset clears both valid flags and loads the register reset values.
// A stalled result holds; the input register still takes a transfer if the
// result register drains in the same cycle.
`default_nettype none

module wait_state_cycle_count
  import wscc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [AddrW-1:0]    address_i,
  input  wire logic [SizeW-1:0]    access_size_i,
  input  wire logic                is_sequential_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [CountW-1:0]        cycle_count_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg;
  logic              a_valid_q;
  logic [AddrW-1:0]  addr_q;
  logic [SizeW-1:0]  size_q;
  logic              seq_q;
  logic              b_valid_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic              b_ready;
  logic              a_adv;
  logic              in_xfer;

  wscc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wscc_cost u_cost (
    .address_i       (addr_q),
    .access_size_i   (size_q),
    .is_sequential_i (seq_q),
    .cfg_i           (cfg),
    .cycle_count_o   (count_d)
  );

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_adv      = a_valid_q && b_ready;
  assign in_ready_o = !a_valid_q || b_ready;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      addr_q <= address_i;
      size_q <= access_size_i;
      seq_q  <= is_sequential_i;
    end
    if (a_adv) begin
      count_q <= count_d;
    end
  end

  assign out_valid_o   = b_valid_q;
  assign cycle_count_o = count_q;

  a_adv_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |=> b_valid_q && (count_q == $past(count_d)))
    else $error("result register missed a decoded cost");

  count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cycle_count_o != 6'd0) && (cycle_count_o <= 6'd32))
    else $error("cycle count out of range");

  stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> a_valid_q && b_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_adv |=> a_valid_q && $stable(addr_q) && $stable(size_q))
    else $error("pending input item lost");

endmodule

`default_nettype wire
